// ===== rtl/rhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhs_pkg: shared constants, types and functions
// Widths, header layout constants, status codes and the CRC-32 byte update.
// ----------------------------------------------------------------------------
package rhs_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned POS_W       = 17;

  localparam logic [31:0] STAMP_MAGIC = 32'h4352_5348;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Header layout, as byte offsets
  localparam int unsigned CRC_FIELD_POS = 16;
  localparam logic [LENGTH_BITS-1:0] MIN_LENGTH = LENGTH_BITS'(CRC_FIELD_POS + 4);

  localparam logic [14:0] WORD_MAGIC  = 15'd0;
  localparam logic [14:0] WORD_LENGTH = 15'd2;
  localparam logic [14:0] WORD_CRC    = 15'(CRC_FIELD_POS / 4);

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LEN  = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc,
                                                input logic [7:0]  data);
    logic [31:0] c;
    c = acc ^ {24'b0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rhs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhs_if: stream channels of the header stamp block
// Input byte channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rhs_in_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      data_byte;
  logic [rhs_pkg::LENGTH_BITS-1:0] record_length;
  logic                            last;

  modport source (output valid, output data_byte, output record_length, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input record_length, input last,
                  output ready);
endinterface

interface rhs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] crc_value;
  logic        record_done;
  logic [1:0]  status;

  modport source (output valid, output out_byte, output crc_value, output record_done,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input crc_value, input record_done,
                  input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/record_header_stamp_crc32.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_header_stamp_crc32: record header patching with CRC-32
// Stamps magic word, length and a zeroed CRC field into each record header
// and accumulates a reflected CRC-32 over the patched bytes.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------------
//  in_if    | sink      | data_byte, record_length, last
//  out_if   | source    | out_byte, crc_value, record_done, status
//  APB      | slave     | buffer_capacity at address 0
//
//  One byte per cycle sustained while out_if takes each result; each result
//  follows its input transfer through the input register, then the result register.
//  The eight-bit CRC update between the two registers sets the clock path.
//  A stall on out_if holds both stages; the input register still fills once.
//  Reset returns capacity to 65535, CRC to all ones and the position to zero.
// ----------------------------------------------------------------------------
module record_header_stamp_crc32 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rhs_in_if.sink           in_if,
  rhs_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned LB = rhs_pkg::LENGTH_BITS;
  localparam int unsigned PW = rhs_pkg::POS_W;

  logic [15:0] capacity;

  rhs_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // input stage
  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic [LB-1:0] s1_len_q;
  logic          s1_last_q;
  logic          s1_adv;
  logic          in_xfer;

  // record state
  logic [31:0]   crc_q, crc_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          lvalid_q, lvalid_d;

  // result stage
  logic          out_valid_q;
  logic [7:0]    out_byte_q, out_byte_d;
  logic [31:0]   out_crc_q, out_crc_d;
  logic          out_done_q;
  logic [1:0]    out_status_q, out_status_d;

  logic          ok_now;
  logic          valid_now;
  logic          in_range;
  logic [31:0]   len_word;
  logic [31:0]   crc_fold;
  logic [PW:0]   pos_inc;

  assign s1_adv       = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !s1_valid_q || s1_adv;
  assign in_xfer      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_if.data_byte;
      s1_len_q  <= in_if.record_length;
      s1_last_q <= in_if.last;
    end
  end

  assign ok_now    = (s1_len_q >= rhs_pkg::MIN_LENGTH) &&
                     ({{(32-LB){1'b0}}, s1_len_q} <= {16'b0, capacity});
  assign valid_now = lvalid_q && ok_now;
  assign in_range  = pos_q < {{(PW-LB){1'b0}}, s1_len_q};
  assign len_word  = {{(32-LB){1'b0}}, s1_len_q};
  assign pos_inc   = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};

  // patch on the word index within the header, select the byte by the low bits
  always_comb begin
    out_byte_d = s1_byte_q;
    if (valid_now && in_range) begin
      case (pos_q[PW-1:2])
        rhs_pkg::WORD_MAGIC:  out_byte_d = rhs_pkg::STAMP_MAGIC[8*pos_q[1:0] +: 8];
        rhs_pkg::WORD_LENGTH: out_byte_d = len_word[8*pos_q[1:0] +: 8];
        rhs_pkg::WORD_CRC:    out_byte_d = 8'h00;
        default:              out_byte_d = s1_byte_q;
      endcase
    end
  end

  assign crc_fold = rhs_pkg::crc_fold_byte(crc_q, out_byte_d);

  always_comb begin
    crc_d        = crc_q;
    pos_d        = pos_q;
    lvalid_d     = lvalid_q;
    out_crc_d    = 32'b0;
    out_status_d = rhs_pkg::STATUS_OK;
    if (s1_adv) begin
      if (valid_now && in_range) begin
        crc_d = crc_fold;
      end
      lvalid_d = valid_now;
      if (s1_last_q) begin
        if (!valid_now) begin
          out_status_d = rhs_pkg::STATUS_BAD_LEN;
        end else begin
          out_crc_d = ~crc_d;
          if ((pos_q == rhs_pkg::POS_MAX) ||
              (pos_inc != {{(PW+1-LB){1'b0}}, s1_len_q})) begin
            out_status_d = rhs_pkg::STATUS_MISMATCH;
          end
        end
        crc_d    = rhs_pkg::CRC_INIT;
        pos_d    = '0;
        lvalid_d = 1'b1;
      end else if (pos_q != rhs_pkg::POS_MAX) begin
        pos_d = pos_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= rhs_pkg::CRC_INIT;
      pos_q       <= '0;
      lvalid_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      crc_q    <= crc_d;
      pos_q    <= pos_d;
      lvalid_q <= lvalid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q   <= out_byte_d;
      out_crc_q    <= out_crc_d;
      out_done_q   <= s1_last_q;
      out_status_q <= out_status_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.out_byte    = out_byte_q;
  assign out_if.crc_value   = out_crc_q;
  assign out_if.record_done = out_done_q;
  assign out_if.status      = out_status_q;

`ifndef NO_ASSERTIONS
  // only the final byte reports a CRC or a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_done_q |-> out_crc_q == 32'b0 && out_status_q == rhs_pkg::STATUS_OK)
    else $error("crc or status on a non-final byte");

  // a rejected length never reports a CRC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == rhs_pkg::STATUS_BAD_LEN |-> out_crc_q == 32'b0)
    else $error("crc reported with bad length");

  // record end restores the start state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> pos_q == '0 && crc_q == rhs_pkg::CRC_INIT && lvalid_q)
    else $error("record state not restored after final byte");

  // an empty result register never blocks the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |-> s1_adv && in_if.ready)
    else $error("pipeline stalled with empty output");
`endif

endmodule
`default_nettype wire

// ===== rtl/rhs_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhs_apb_regs: configuration register file
// Holds buffer_capacity at byte addresses 0 to 3; addresses 4 to 7 read as zero.
// ----------------------------------------------------------------------------
module rhs_apb_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [15:0] capacity_o
);

  logic [15:0] capacity_q, capacity_d;
  logic        sel_cap;
  logic        wr_en;

  // decode on the word index, byte lanes ignored
  assign sel_cap = (paddr[2] == 1'b0);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    capacity_d = capacity_q;
    if (wr_en && sel_cap) begin
      capacity_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= rhs_pkg::CAPACITY_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign prdata     = sel_cap ? {16'b0, capacity_q} : 32'b0;
  assign capacity_o = capacity_q;

endmodule
`default_nettype wire
